>>> sv/psrac_pkg.sv
// Package for the shadow RAM attribute controller.
// Holds request codes, controller states, command struct and fixed constants.
// No dependencies.
package psrac_pkg;

  typedef enum logic [1:0] {
    REQ_CFG_RD = 2'd0,
    REQ_CFG_WR = 2'd1,
    REQ_MEM_RD = 2'd2,
    REQ_MEM_WR = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic mem_rd;
    logic commit;
  } cmd_t;

  localparam logic [1:0] ROUTE_NONE = 2'd0;
  localparam logic [1:0] ROUTE_ROM  = 2'd1;
  localparam logic [1:0] ROUTE_RAM  = 2'd2;

  localparam logic [31:0] ID_WORD    = 32'h7100_8086;
  localparam logic [31:0] REV_WORD   = 32'h0000_0001;
  localparam logic [31:0] RST_SLOT0  = 32'h1402_0000;
  localparam logic [31:0] RST_SLOT1  = 32'h0152_0000;
  localparam logic [31:0] RST_SLOT4  = 32'h0202_0202;
  localparam logic [31:0] RST_SLOT5  = 32'h0000_0002;

  localparam logic [19:0] WIN_BASE = 20'hC0000;
  localparam logic [19:0] TOP_BASE = 20'hF0000;

  localparam logic [7:0] OFF_ID   = 8'h00;
  localparam logic [7:0] OFF_REV  = 8'h08;
  localparam logic [7:0] OFF_PAM0 = 8'h58;
  localparam logic [7:0] OFF_PAM1 = 8'h5C;
  localparam logic [7:0] OFF_WO0  = 8'h70;
  localparam logic [7:0] OFF_WO1  = 8'h74;
  localparam logic [7:0] OFF_RO4C = 8'h4C;

  localparam int CFG_SLOTS = 16;
  localparam int SEGMENTS  = 13;

endpackage

>>> sv/psrac_ctrl.sv
// Controller state machine for the shadow RAM attribute controller.
// Sequences accept, shadow RAM read and commit; depends on psrac_pkg.
module psrac_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output psrac_pkg::cmd_t  cmd
);

  psrac_pkg::state_t state;
  psrac_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      psrac_pkg::ST_IDLE: begin
        if (start) begin
          state_next = psrac_pkg::ST_READ;
        end
      end
      psrac_pkg::ST_READ: begin
        state_next = psrac_pkg::ST_RESP;
      end
      psrac_pkg::ST_RESP: begin
        state_next = psrac_pkg::ST_IDLE;
      end
      default: begin
        state_next = psrac_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.mem_rd = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      psrac_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      psrac_pkg::ST_READ: begin
        cmd.mem_rd = 1'b1;
      end
      psrac_pkg::ST_RESP: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psrac_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

endmodule

>>> sv/psrac_datapath.sv
// Datapath for the shadow RAM attribute controller.
// Holds config words, segment attributes, shadow RAM and result registers.
// Depends on psrac_pkg; driven by psrac_ctrl commands.
module psrac_datapath #(
  parameter int SHADOW_WORDS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  psrac_pkg::cmd_t  cmd,
  input  logic [1:0]       req_type,
  input  logic [2:0]       function_number,
  input  logic [7:0]       reg_offset,
  input  logic [19:0]      mem_address,
  input  logic [31:0]      write_data,
  input  logic [31:0]      lane_mask,
  output logic [31:0]      read_data,
  output logic [1:0]       route,
  output logic [17:0]      rom_offset,
  output logic             error
);

  localparam int AW = $clog2(SHADOW_WORDS);
  localparam logic [17:0] N1 = 18'(SHADOW_WORDS);
  localparam logic [17:0] N2 = 18'(2 * SHADOW_WORDS);

  psrac_pkg::req_t req;
  logic [2:0]      func;
  logic [7:0]      off;
  logic [19:0]     addr;
  logic [31:0]     data;
  logic [31:0]     mask;

  logic [31:0] cfg_words [psrac_pkg::CFG_SLOTS];
  logic [1:0]  seg_attr [psrac_pkg::SEGMENTS];
  logic [31:0] shadow [SHADOW_WORDS];
  logic [31:0] mem_q;

  logic [17:0]   rel;
  logic [17:0]   w0;
  logic [17:0]   w1;
  logic [17:0]   w2;
  logic [AW-1:0] idx;
  logic [3:0]    seg;
  logic [1:0]    attr;
  logic [3:0]    slot;
  logic          slot_ok;
  logic          reads_zero;
  logic          wr_dropped;
  logic [31:0]   cfg_word;

  logic [31:0] res_rd;
  logic [1:0]  res_route;
  logic [17:0] res_rom;
  logic        res_err;
  logic        cfg_we;
  logic        pam0_we;
  logic        pam1_we;
  logic        mem_we;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= psrac_pkg::req_t'(req_type);
      func <= function_number;
      off  <= reg_offset;
      addr <= mem_address;
      data <= write_data;
      mask <= lane_mask;
    end
  end

  assign rel = 18'(addr - psrac_pkg::WIN_BASE);
  assign w0  = {2'b00, rel[17:2]};
  assign w1  = (w0 >= N2) ? (w0 - N2) : w0;
  assign w2  = (w1 >= N1) ? (w1 - N1) : w1;
  assign idx = w2[AW-1:0];
  assign seg = (addr >= psrac_pkg::TOP_BASE) ? 4'd0 : (4'd1 + rel[17:14]);
  assign attr = seg_attr[seg];

  always_comb begin
    slot_ok = 1'b1;
    slot    = 4'd0;
    case (off)
      8'h50:   slot = 4'd0;
      8'h54:   slot = 4'd1;
      8'h58:   slot = 4'd2;
      8'h5C:   slot = 4'd3;
      8'h60:   slot = 4'd4;
      8'h64:   slot = 4'd5;
      8'h68:   slot = 4'd6;
      8'h04:   slot = 4'd7;
      8'h0C:   slot = 4'd8;
      8'h70:   slot = 4'd9;
      8'h74:   slot = 4'd10;
      8'h78:   slot = 4'd11;
      8'hC0:   slot = 4'd12;
      8'hE0:   slot = 4'd13;
      default: slot_ok = 1'b0;
    endcase
  end

  assign reads_zero = ((off inside {[8'h10:8'h3C]}) && off[1:0] == 2'b00) ||
                      off == psrac_pkg::OFF_RO4C;
  assign wr_dropped = off == psrac_pkg::OFF_ID ||
                      ((off inside {[8'h10:8'h30]}) && off[1:0] == 2'b00) ||
                      off == 8'h3C || off == psrac_pkg::OFF_RO4C;
  assign cfg_word = cfg_words[slot];

  always_comb begin
    res_rd    = 32'd0;
    res_route = psrac_pkg::ROUTE_NONE;
    res_rom   = 18'd0;
    res_err   = 1'b0;
    cfg_we    = 1'b0;
    pam0_we   = 1'b0;
    pam1_we   = 1'b0;
    mem_we    = 1'b0;
    case (req)
      psrac_pkg::REQ_CFG_RD: begin
        if (func == 3'd0) begin
          if (off == psrac_pkg::OFF_ID) begin
            res_rd = psrac_pkg::ID_WORD;
          end else if (off == psrac_pkg::OFF_REV) begin
            res_rd = psrac_pkg::REV_WORD;
          end else if (reads_zero) begin
            res_rd = 32'd0;
          end else if (slot_ok && off != psrac_pkg::OFF_WO0 &&
                       off != psrac_pkg::OFF_WO1) begin
            res_rd = cfg_word;
          end else begin
            res_err = 1'b1;
          end
        end
      end
      psrac_pkg::REQ_CFG_WR: begin
        if (func == 3'd0) begin
          if (wr_dropped) begin
            cfg_we = 1'b0;
          end else if (slot_ok) begin
            cfg_we  = 1'b1;
            pam0_we = off == psrac_pkg::OFF_PAM0;
            pam1_we = off == psrac_pkg::OFF_PAM1;
          end else begin
            res_err = 1'b1;
          end
        end
      end
      default: begin
        if (addr < psrac_pkg::WIN_BASE) begin
          res_err = 1'b1;
        end else if (req == psrac_pkg::REQ_MEM_RD) begin
          if (attr[0]) begin
            res_route = psrac_pkg::ROUTE_RAM;
            res_rd    = mem_q;
          end else begin
            res_route = psrac_pkg::ROUTE_ROM;
            res_rom   = rel;
          end
        end else if (attr[1]) begin
          res_route = psrac_pkg::ROUTE_RAM;
          mem_we    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < psrac_pkg::CFG_SLOTS; i++) begin
        if (i != 0 && i != 1 && i != 4 && i != 5) begin
          cfg_words[i] <= 32'd0;
        end
      end
      cfg_words[0] <= psrac_pkg::RST_SLOT0;
      cfg_words[1] <= psrac_pkg::RST_SLOT1;
      cfg_words[4] <= psrac_pkg::RST_SLOT4;
      cfg_words[5] <= psrac_pkg::RST_SLOT5;
      for (int i = 0; i < psrac_pkg::SEGMENTS; i++) begin
        seg_attr[i] <= 2'd0;
      end
    end else if (cmd.commit) begin
      if (cfg_we) begin
        cfg_words[slot] <= (cfg_word & ~mask) | (data & mask);
      end
      for (int i = 0; i < 5; i++) begin
        if (pam0_we && mask[(i + 3) * 4 +: 4] != 4'd0) begin
          seg_attr[i] <= data[(i + 3) * 4 +: 2];
        end
      end
      for (int i = 0; i < 8; i++) begin
        if (pam1_we && mask[i * 4 +: 4] != 4'd0) begin
          seg_attr[5 + i] <= data[i * 4 +: 2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      mem_q <= shadow[idx];
    end
    if (cmd.commit && mem_we) begin
      shadow[idx] <= (mem_q & ~mask) | (data & mask);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data  <= res_rd;
      route      <= res_route;
      rom_offset <= res_rom;
      error      <= res_err;
    end
  end

endmodule

>>> sv/pci_shadow_ram_attribute_controller_top.sv
// Top level of the shadow RAM attribute controller; depends on psrac_pkg.
// Sequence: the controller accepts in idle, reads the shadow RAM, then commits; done and
// the result are registered at the commit, and no new transaction is accepted until idle.
// The three-state controller steps through accept, shadow RAM read, then commit.
// Memory writes are read-modify-write on the single shadow RAM port.
// Reset restores config words and clears segment attributes; shadow RAM is not cleared.
// The receiver cannot stall: done is a one-cycle strobe.
module pci_shadow_ram_attribute_controller_top #(
  parameter int SHADOW_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [2:0]  function_number,
  input  logic [7:0]  reg_offset,
  input  logic [19:0] mem_address,
  input  logic [31:0] write_data,
  input  logic [31:0] lane_mask,
  output logic        done,
  output logic [31:0] read_data,
  output logic [1:0]  route,
  output logic [17:0] rom_offset,
  output logic        error
);

  psrac_pkg::cmd_t cmd;

  psrac_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  psrac_datapath #(
    .SHADOW_WORDS (SHADOW_WORDS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .req_type        (req_type),
    .function_number (function_number),
    .reg_offset      (reg_offset),
    .mem_address     (mem_address),
    .write_data      (write_data),
    .lane_mask       (lane_mask),
    .read_data       (read_data),
    .route           (route),
    .rom_offset      (rom_offset),
    .error           (error)
  );

endmodule

>>> sv/psrac_checker.sv
// Port-level checker for the shadow RAM attribute controller top level.
// Bound to pci_shadow_ram_attribute_controller_top; depends on psrac_pkg.
module psrac_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  route,
  input logic [17:0] rom_offset,
  input logic        error
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done set after reset");

  a_done_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("transaction result not strobed three cycles after accept");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while a result is strobed");

  a_error_route: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> route == psrac_pkg::ROUTE_NONE)
    else $error("error result carries a route");

  a_rom_offset: assert property (@(posedge clk) disable iff (rst)
    (done && route != psrac_pkg::ROUTE_ROM) |-> rom_offset == 18'd0)
    else $error("ROM offset set on a non-ROM result");

endmodule

bind pci_shadow_ram_attribute_controller_top psrac_checker u_psrac_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the shadow RAM attribute controller top level.
// Feeds config and memory transactions through start/busy and checks every done
// strobe against an in-bench model. Depends on psrac_pkg and the RTL top.
`timescale 1ns / 100ps

module tb;
  import psrac_pkg::*;

  localparam int SHADOW_WORDS = 65536;
  localparam int DIRECTED_COUNT = 27;
  localparam int TOTAL_ITEMS = 1550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL_SIZE = 48;

  localparam logic [7:0] OFF_CMD    = 8'h04;
  localparam logic [7:0] OFF_HDR    = 8'h0C;
  localparam logic [7:0] OFF_BAR_LO = 8'h10;
  localparam logic [7:0] OFF_BAR_HI = 8'h30;
  localparam logic [7:0] OFF_RO34   = 8'h34;
  localparam logic [7:0] OFF_RO38   = 8'h38;
  localparam logic [7:0] OFF_INT    = 8'h3C;
  localparam logic [7:0] OFF_CTL0   = 8'h50;
  localparam logic [7:0] OFF_CTL1   = 8'h54;
  localparam logic [7:0] OFF_DRB0   = 8'h60;
  localparam logic [7:0] OFF_DRB1   = 8'h64;
  localparam logic [7:0] OFF_DRT    = 8'h68;
  localparam logic [7:0] OFF_SMR    = 8'h78;
  localparam logic [7:0] OFF_CC0    = 8'hC0;
  localparam logic [7:0] OFF_CE0    = 8'hE0;

  typedef struct packed {
    req_t        kind;
    logic [2:0]  func;
    logic [7:0]  off;
    logic [19:0] addr;
    logic [31:0] data;
    logic [31:0] mask;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  route;
    logic [17:0] romoff;
    logic        err;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  access_t drv = '0;

  logic        busy;
  logic        done;
  logic [31:0] read_data;
  logic [1:0]  route;
  logic [17:0] rom_offset;
  logic        error;

  access_t pending_q[$];
  result_t expected_q[$];

  logic [31:0] cfg_model [CFG_SLOTS];
  logic [25:0] attr_model;
  logic [31:0] shadow_model [SHADOW_WORDS];

  logic [25:0] gen_attrs;
  bit          gen_defined [SHADOW_WORDS];
  logic [19:0] addr_pool [POOL_SIZE];

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  pci_shadow_ram_attribute_controller_top #(
    .SHADOW_WORDS(SHADOW_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(drv.kind),
    .function_number(drv.func),
    .reg_offset(drv.off),
    .mem_address(drv.addr),
    .write_data(drv.data),
    .lane_mask(drv.mask),
    .done(done),
    .read_data(read_data),
    .route(route),
    .rom_offset(rom_offset),
    .error(error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int cfg_slot(logic [7:0] off);
    case (off)
      OFF_CTL0: return 0;
      OFF_CTL1: return 1;
      OFF_PAM0: return 2;
      OFF_PAM1: return 3;
      OFF_DRB0: return 4;
      OFF_DRB1: return 5;
      OFF_DRT:  return 6;
      OFF_CMD:  return 7;
      OFF_HDR:  return 8;
      OFF_WO0:  return 9;
      OFF_WO1:  return 10;
      OFF_SMR:  return 11;
      OFF_CC0:  return 12;
      OFF_CE0:  return 13;
      default:  return -1;
    endcase
  endfunction

  function automatic bit reads_zero(logic [7:0] off);
    return (off >= OFF_BAR_LO && off <= OFF_INT && off[1:0] == 2'b00) || off == OFF_RO4C;
  endfunction

  function automatic bit write_dropped(logic [7:0] off);
    return off == OFF_ID || (off >= OFF_BAR_LO && off <= OFF_BAR_HI && off[1:0] == 2'b00) ||
           off == OFF_INT || off == OFF_RO4C;
  endfunction

  function automatic int segment_of(logic [19:0] addr);
    logic [19:0] rel;
    rel = addr - WIN_BASE;
    return (addr >= TOP_BASE) ? 0 : 1 + int'(rel[17:14]);
  endfunction

  function automatic int shadow_idx(logic [19:0] addr);
    logic [19:0] rel;
    rel = addr - WIN_BASE;
    return int'(rel[19:2]) % SHADOW_WORDS;
  endfunction

  function automatic logic [25:0] pam_update(logic [25:0] attrs, logic [7:0] off,
                                             logic [31:0] data, logic [31:0] mask);
    int sh;
    logic [25:0] next;
    next = attrs;
    if (off == OFF_PAM0) begin
      for (int i = 0; i < 5; i++) begin
        sh = (3 + i) * 4;
        if (mask[sh +: 4] != 4'h0) next[2 * i +: 2] = data[sh +: 2];
      end
    end else if (off == OFF_PAM1) begin
      for (int i = 0; i < 8; i++) begin
        sh = i * 4;
        if (mask[sh +: 4] != 4'h0) next[2 * (5 + i) +: 2] = data[sh +: 2];
      end
    end
    return next;
  endfunction

  task automatic predict_access(input access_t a, output result_t r);
    int s;
    int idx;
    logic [1:0] attr;
    logic [19:0] rel;
    r = '0;
    s = cfg_slot(a.off);
    if (a.kind == REQ_CFG_RD) begin
      if (a.func == 3'd0) begin
        if (a.off == OFF_ID) r.rdata = ID_WORD;
        else if (a.off == OFF_REV) r.rdata = REV_WORD;
        else if (reads_zero(a.off)) r.rdata = '0;
        else if (s >= 0 && a.off != OFF_WO0 && a.off != OFF_WO1) r.rdata = cfg_model[s];
        else r.err = 1'b1;
      end
    end else if (a.kind == REQ_CFG_WR) begin
      if (a.func == 3'd0 && !write_dropped(a.off)) begin
        if (s >= 0) begin
          attr_model = pam_update(attr_model, a.off, a.data, a.mask);
          cfg_model[s] = (cfg_model[s] & ~a.mask) | (a.data & a.mask);
        end else begin
          r.err = 1'b1;
        end
      end
    end else if (a.addr < WIN_BASE) begin
      r.err = 1'b1;
    end else begin
      rel = a.addr - WIN_BASE;
      attr = attr_model[2 * segment_of(a.addr) +: 2];
      idx = shadow_idx(a.addr);
      if (a.kind == REQ_MEM_RD) begin
        if (attr[0]) begin
          r.route = ROUTE_RAM;
          r.rdata = shadow_model[idx];
        end else begin
          r.route = ROUTE_ROM;
          r.romoff = rel[17:0];
        end
      end else if (attr[1]) begin
        r.route = ROUTE_RAM;
        shadow_model[idx] = (shadow_model[idx] & ~a.mask) | (a.data & a.mask);
      end
    end
  endtask

  // A shadow word becomes defined by its first RAM write, whose mask is forced full;
  // RAM-routed reads of undefined words are turned into writes before they are queued.
  task automatic queue_access(input access_t a);
    int idx;
    logic [1:0] attr;
    if (a.kind == REQ_CFG_WR && a.func == 3'd0)
      gen_attrs = pam_update(gen_attrs, a.off, a.data, a.mask);
    if (a.kind[1] && a.addr >= WIN_BASE) begin
      attr = gen_attrs[2 * segment_of(a.addr) +: 2];
      idx = shadow_idx(a.addr);
      if (a.kind == REQ_MEM_RD && attr[0] && !gen_defined[idx]) a.kind = REQ_MEM_WR;
      if (a.kind == REQ_MEM_WR && attr[1]) begin
        if (!gen_defined[idx]) a.mask = '1;
        gen_defined[idx] = 1'b1;
      end
    end
    pending_q.push_back(a);
  endtask

  task automatic push_req(input req_t kind, input logic [2:0] func, input logic [7:0] off,
                          input logic [19:0] addr, input logic [31:0] data,
                          input logic [31:0] mask);
    access_t a;
    a.kind = kind;
    a.func = func;
    a.off = off;
    a.addr = addr;
    a.data = data;
    a.mask = mask;
    queue_access(a);
  endtask

  function automatic logic [7:0] known_offset(int n);
    case (n)
      0:  return OFF_ID;
      1:  return OFF_CMD;
      2:  return OFF_REV;
      3:  return OFF_HDR;
      4:  return OFF_BAR_LO;
      5:  return OFF_BAR_HI;
      6:  return OFF_RO34;
      7:  return OFF_RO38;
      8:  return OFF_INT;
      9:  return OFF_RO4C;
      10: return OFF_CTL0;
      11: return OFF_CTL1;
      12: return OFF_PAM0;
      13: return OFF_PAM1;
      14: return OFF_DRB0;
      15: return OFF_DRB1;
      16: return OFF_DRT;
      17: return OFF_WO0;
      18: return OFF_WO1;
      19: return OFF_SMR;
      20: return OFF_CC0;
      default: return OFF_CE0;
    endcase
  endfunction

  function automatic access_t random_access();
    access_t a;
    int pick;
    a = '0;
    pick = $urandom_range(0, 99);
    a.func = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    a.data = $urandom;
    case ($urandom_range(0, 5))
      0: a.mask = '0;
      1, 2: a.mask = '1;
      default: a.mask = $urandom;
    endcase
    a.off = ($urandom_range(0, 4) == 0) ? 8'($urandom) : known_offset($urandom_range(0, 21));
    case ($urandom_range(0, 19))
      0: a.addr = 20'($urandom_range(0, WIN_BASE - 1));
      1, 2, 3, 4, 5, 6, 7, 8, 9: a.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)] |
                                          20'($urandom_range(0, 3));
      default: a.addr = 20'($urandom_range(WIN_BASE, 20'hFFFFF));
    endcase
    if (pick < 12) begin
      a.kind = REQ_CFG_RD;
    end else if (pick < 24) begin
      a.kind = REQ_CFG_WR;
      if ($urandom_range(0, 1)) a.off = $urandom_range(0, 1) ? OFF_PAM0 : OFF_PAM1;
    end else if (pick < 62) begin
      a.kind = REQ_MEM_WR;
    end else begin
      a.kind = REQ_MEM_RD;
    end
    return a;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
    mismatches++;
  endtask

  initial begin
    for (int i = 0; i < CFG_SLOTS; i++) cfg_model[i] = '0;
    cfg_model[0] = RST_SLOT0;
    cfg_model[1] = RST_SLOT1;
    cfg_model[4] = RST_SLOT4;
    cfg_model[5] = RST_SLOT5;
    attr_model = '0;
    gen_attrs = '0;
    for (int i = 0; i < SHADOW_WORDS; i++) begin
      shadow_model[i] = '0;
      gen_defined[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++)
      addr_pool[i] = 20'($urandom_range(WIN_BASE, 20'hFFFFF)) & 20'hFFFFC;

    push_req(REQ_CFG_RD, 3'd0, OFF_ID, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_REV, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_BAR_LO, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_INT, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_RO4C, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_CTL0, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_WO0, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_CTL0 + 8'd1, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd7, OFF_ID, '0, '0, '0);
    push_req(REQ_CFG_WR, 3'd0, OFF_ID, '0, '1, '1);
    push_req(REQ_CFG_WR, 3'd0, OFF_REV, '0, '1, '1);
    push_req(REQ_CFG_WR, 3'd0, OFF_RO34, '0, '1, '1);
    push_req(REQ_CFG_WR, 3'd5, OFF_CTL0, '0, '1, '1);
    push_req(REQ_CFG_WR, 3'd0, OFF_WO1, '0, $urandom, '1);
    push_req(REQ_MEM_RD, 3'd0, '0, 20'h00000, '0, '0);
    push_req(REQ_MEM_WR, 3'd0, '0, WIN_BASE - 20'd1, '1, '1);
    push_req(REQ_MEM_RD, 3'd0, '0, WIN_BASE, '0, '0);
    push_req(REQ_MEM_RD, 3'd7, '0, 20'hFFFFF, '0, '0);
    push_req(REQ_MEM_WR, 3'd0, '0, WIN_BASE, '1, '1);
    push_req(REQ_CFG_WR, 3'd0, OFF_PAM0, 32'h3333_3333, '1, '1);
    push_req(REQ_CFG_WR, 3'd0, OFF_PAM1, 32'h2121_2121, '1, '1);
    push_req(REQ_MEM_WR, 3'd0, '0, 20'hFFFFC, '1, '1);
    push_req(REQ_MEM_RD, 3'd0, '0, 20'hFFFFF, '0, '0);
    push_req(REQ_MEM_WR, 3'd0, '0, WIN_BASE, '0, '1);
    push_req(REQ_MEM_RD, 3'd0, '0, WIN_BASE + 20'd2, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_PAM0, '0, '0, '0);
    push_req(REQ_CFG_RD, 3'd0, OFF_PAM1, '0, '0, '0);
    for (int i = DIRECTED_COUNT; i < TOTAL_ITEMS; i++) queue_access(random_access());

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin : drive
    result_t want;
    access_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_access(drv, want);
        expected_q.push_back(want);
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        drv <= nxt;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check
    result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected result, read_data", '0, read_data);
      end else begin
        want = expected_q.pop_front();
        if (read_data !== want.rdata) flag_mismatch("read_data", want.rdata, read_data);
        if (route !== want.route) flag_mismatch("route", 32'(want.route), 32'(route));
        if (rom_offset !== want.romoff)
          flag_mismatch("rom_offset", 32'(want.romoff), 32'(rom_offset));
        if (error !== want.err) flag_mismatch("error", 32'(want.err), 32'(error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
